[src/lfu_hit_counter_table_core_assert.svh]
// Assertion macros shared by the hit counter table RTL.
`ifndef LFU_HIT_COUNTER_TABLE_CORE_ASSERT_SVH
`define LFU_HIT_COUNTER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define LHCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define LHCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lhct_pkg.sv]
// Types, state codes and key helper for the hit counter table.
`default_nettype none

package lhct_pkg;

    typedef struct packed {
        logic [63:0] name_high;
        logic [63:0] name_low;
        logic [31:0] hit_count;
        logic [31:0] last_time;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_RD   = 5'b00100,
        S_RDW  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    localparam int KEY_BYTES = 16;

    // Zero every key byte that follows the first zero byte.
    function automatic logic [127:0] clean_key(input logic [127:0] key);
        logic [127:0] res;
        logic         ended;
        res = key;
        for (int i = 0; i < KEY_BYTES; i++) begin
            ended = 1'b0;
            for (int j = 0; j < i; j++) begin
                ended = ended | (key[127 - 8 * j -: 8] == 8'h00);
            end
            if (ended) begin
                res[127 - 8 * i -: 8] = 8'h00;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/lfu_hit_counter_table_core.sv]
// Top level of the least-frequently-used hit counter table.
// Input channel: i_valid / o_stall, one beat per request. i_func 0 records a hit
// for a present 16-byte key, i_func 1 reads the slot at i_read_index.
// Output channel: o_valid / i_stall, exactly one result beat per request.
// A record request walks the table through one RAM read port, one slot per
// cycle, and ends early when the key or an unused slot is found. A read request
// of a slot past the fill count returns zero contents without a RAM read.
// One request is in flight at a time; o_stall is high from acceptance until the
// result is loaded into the output register, so a new request can start only
// after the previous result has been loaded.
// The output register lets the next request be accepted while a result waits.
// While i_stall holds a result, a finished request waits in its last step.
// Reset clears the fill count, so every slot reads as unused with zero contents;
// no clearing pass is needed and the block is ready the cycle after reset.
`default_nettype none
`include "lfu_hit_counter_table_core_assert.svh"

module lfu_hit_counter_table_core #(
    parameter int ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [63:0] i_key_high,
    input  wire logic [63:0] i_key_low,
    input  wire logic        i_key_present,
    input  wire logic [31:0] i_now_time,
    input  wire logic [5:0]  i_read_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_slot,
    output logic             o_matched,
    output logic             o_written,
    output logic [31:0]      o_hit_count,
    output logic [31:0]      o_last_time,
    output logic [63:0]      o_name_high,
    output logic [63:0]      o_name_low,
    output logic             o_slot_used
);

    import lhct_pkg::*;

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    t_state         r_state, n_state;
    logic [127:0]   r_key, n_key;
    logic           r_present, n_present;
    logic [31:0]    r_now, n_now;
    logic [5:0]     r_ridx, n_ridx;
    logic [CW-1:0]  r_icnt, n_icnt;
    logic           r_dv, n_dv;
    logic [IW-1:0]  r_didx, n_didx;
    logic [IW-1:0]  r_pick, n_pick;
    logic [31:0]    r_min, n_min;
    t_entry         r_pick_ent, n_pick_ent;
    t_entry         r_res, n_res;
    logic [5:0]     r_slot, n_slot;
    logic           r_matched, n_matched;
    logic           r_written, n_written;
    logic           r_grow, n_grow;
    logic [CW-1:0]  r_fill, n_fill;
    logic           r_ovalid, n_ovalid;
    t_entry         r_out, n_out;
    logic [5:0]     r_oslot, n_oslot;
    logic           r_omatched, n_omatched;
    logic           r_owritten, n_owritten;

    logic           ram_we;
    logic           ram_re;
    logic [IW-1:0]  ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry         rd;
    logic           key_eq;

    assign rd     = t_entry'(ram_rdata);
    assign key_eq = (rd.name_high == r_key[127:64]) && (rd.name_low == r_key[63:0]);

    lhct_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pick),
        .i_wdata (r_res),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic          fin;
        logic [IW-1:0] fin_pick;
        t_entry        fin_base;
        logic          fin_match;
        logic          fin_grow;

        fin        = 1'b0;
        fin_pick   = r_pick;
        fin_base   = r_pick_ent;
        fin_match  = 1'b0;
        fin_grow   = 1'b0;

        n_state    = r_state;
        n_key      = r_key;
        n_present  = r_present;
        n_now      = r_now;
        n_ridx     = r_ridx;
        n_icnt     = r_icnt;
        n_dv       = 1'b0;
        n_didx     = r_icnt[IW-1:0];
        n_pick     = r_pick;
        n_min      = r_min;
        n_pick_ent = r_pick_ent;
        n_res      = r_res;
        n_slot     = r_slot;
        n_matched  = r_matched;
        n_written  = r_written;
        n_grow     = r_grow;
        n_fill     = r_fill;
        n_ovalid   = r_ovalid && i_stall;
        n_out      = r_out;
        n_oslot    = r_oslot;
        n_omatched = r_omatched;
        n_owritten = r_owritten;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_icnt[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key     = clean_key({i_key_high, i_key_low});
                    n_present = i_key_present;
                    n_now     = i_now_time;
                    n_ridx    = i_read_index;
                    n_icnt    = '0;
                    n_state   = i_func ? S_RD : S_SCAN;
                end
            end
            S_RD: begin
                ram_raddr = IW'(r_ridx);
                n_slot    = r_ridx;
                n_matched = 1'b0;
                n_written = 1'b0;
                n_grow    = 1'b0;
                if (CMPW'(r_ridx) < CMPW'(r_fill)) begin
                    ram_re  = 1'b1;
                    n_state = S_RDW;
                end else begin
                    n_res   = '0;
                    n_state = S_EMIT;
                end
            end
            S_RDW: begin
                n_res   = rd;
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (r_icnt < r_fill) begin
                    ram_re = 1'b1;
                    n_dv   = 1'b1;
                    n_icnt = r_icnt + CW'(1);
                end
                if (r_dv) begin
                    if (rd.name_high[63:56] == 8'h00) begin
                        fin      = 1'b1;
                        fin_pick = r_didx;
                        fin_base = rd;
                    end else if (r_present && key_eq) begin
                        fin       = 1'b1;
                        fin_pick  = r_didx;
                        fin_base  = rd;
                        fin_match = 1'b1;
                    end else if (r_didx == IW'(0) || rd.hit_count < r_min) begin
                        n_min      = rd.hit_count;
                        n_pick     = r_didx;
                        n_pick_ent = rd;
                    end
                end else if (r_icnt == r_fill) begin
                    fin = 1'b1;
                    if (r_fill < CW'(ENTRIES)) begin
                        fin_pick = r_fill[IW-1:0];
                        fin_base = '0;
                        fin_grow = 1'b1;
                    end
                end
                if (fin) begin
                    n_pick    = fin_pick;
                    n_slot    = 6'(fin_pick);
                    n_matched = fin_match;
                    n_written = r_present;
                    n_grow    = fin_grow && r_present;
                    if (fin_match) begin
                        n_res           = fin_base;
                        n_res.hit_count = (fin_base.hit_count == 32'hFFFF_FFFF) ?
                                          fin_base.hit_count : fin_base.hit_count + 32'd1;
                        n_res.last_time = r_now;
                    end else if (r_present) begin
                        n_res.name_high = r_key[127:64];
                        n_res.name_low  = r_key[63:0];
                        n_res.hit_count = 32'd1;
                        n_res.last_time = r_now;
                    end else begin
                        n_res = fin_base;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid   = 1'b1;
                    n_out      = r_res;
                    n_oslot    = r_slot;
                    n_omatched = r_matched;
                    n_owritten = r_written;
                    ram_we     = r_written;
                    if (r_grow) begin
                        n_fill = r_fill + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
            r_icnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
            r_dv     <= n_dv;
            r_icnt   <= n_icnt;
        end
        r_key      <= n_key;
        r_present  <= n_present;
        r_now      <= n_now;
        r_ridx     <= n_ridx;
        r_didx     <= n_didx;
        r_pick     <= n_pick;
        r_min      <= n_min;
        r_pick_ent <= n_pick_ent;
        r_res      <= n_res;
        r_slot     <= n_slot;
        r_matched  <= n_matched;
        r_written  <= n_written;
        r_grow     <= n_grow;
        r_out      <= n_out;
        r_oslot    <= n_oslot;
        r_omatched <= n_omatched;
        r_owritten <= n_owritten;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_slot      = r_oslot;
    assign o_matched   = r_omatched;
    assign o_written   = r_owritten;
    assign o_hit_count = r_out.hit_count;
    assign o_last_time = r_out.last_time;
    assign o_name_high = r_out.name_high;
    assign o_name_low  = r_out.name_low;
    assign o_slot_used = (r_out.name_high[63:56] != 8'h00);

    `LHCT_ASSERT_NOW(a_fill_max, 1'b1, r_fill <= CW'(ENTRIES), "fill count beyond table depth")
    `LHCT_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_icnt <= r_fill, "scan read past fill")
    `LHCT_ASSERT_NOW(a_grow_slot, r_state == S_EMIT && r_grow, r_written && CW'(r_pick) == r_fill, "bad grow")
    `LHCT_ASSERT_NEXT(a_fill_hold, r_state != S_EMIT, $stable(r_fill), "fill changed outside write-back")
    `LHCT_ASSERT_NOW(a_match_write, o_valid && o_matched, o_written, "match reported without write")

endmodule

`default_nettype wire

[src/lhct_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module lhct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
